[sv/actr_pkg.sv]
package actr_pkg;

  localparam int RoundCount = 14;
  localparam int WordW      = 64;
  localparam int BlockW     = 128;
  localparam int CountW     = 5;
  localparam int IndexW     = 3;
  localparam int KeyWords   = 8;

  typedef enum logic [IndexW-1:0] {
    REG_KEY0  = 3'd0,
    REG_KEY1  = 3'd1,
    REG_KEY2  = 3'd2,
    REG_KEY3  = 3'd3,
    REG_NONCE = 3'd4,
    REG_START = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

  localparam logic [7:0] Rcon [8] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
  };

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sub_byte(input logic [7:0] x);
    return Sbox[x];
  endfunction

  function automatic logic [31:0] subst_bytes32(input logic [31:0] w);
    return {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]), sub_byte(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // One cipher round without the key addition; the last round skips column mixing
  function automatic logic [BlockW-1:0] aes_round(input logic [BlockW-1:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [BlockW-1:0] r;
    for (int k = 0; k < 16; k++) begin
      b[k] = s[BlockW-1-8*k -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[4*c+j] = sub_byte(b[4*((c+j)%4)+j]);
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c];
        a1 = t[4*c+1];
        a2 = t[4*c+2];
        a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int k = 0; k < 16; k++) begin
      r[BlockW-1-8*k -: 8] = t[k];
    end
    return r;
  endfunction

endpackage

[sv/actr_if.sv]
interface actr_in_if;
  logic                         valid;
  logic                         ready;
  logic [actr_pkg::WordW-1:0]   data_high;
  logic [actr_pkg::WordW-1:0]   data_low;
  logic [actr_pkg::CountW-1:0]  valid_bytes;

  modport source (output valid, data_high, data_low, valid_bytes, input ready);
  modport sink (input valid, data_high, data_low, valid_bytes, output ready);
endinterface

interface actr_out_if;
  logic                        valid;
  logic                        ready;
  logic [actr_pkg::WordW-1:0]  result_high;
  logic [actr_pkg::WordW-1:0]  result_low;
  logic                        counter_wrapped;

  modport source (output valid, result_high, result_low, counter_wrapped, input ready);
  modport sink (input valid, result_high, result_low, counter_wrapped, output ready);
endinterface

[sv/actr_key_store.sv]
module actr_key_store #(
  parameter int ROUND_COUNT = actr_pkg::RoundCount
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              restart,
  input  logic [7:0][31:0]                  key,
  input  logic [$clog2(ROUND_COUNT+1)-1:0]  rd_row,
  output logic [actr_pkg::BlockW-1:0]       rd_key,
  output logic                              busy
);
  import actr_pkg::*;

  localparam int Rows   = ROUND_COUNT + 1;
  localparam int Words  = 4 * Rows;
  localparam int RowW   = $clog2(Rows);
  localparam int IdxW   = $clog2(Words);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Words - 1);

  logic [3:0][31:0] rk_mem [Rows];
  logic [31:0]      win [KeyWords];
  logic [IdxW-1:0]  idx;
  logic [31:0]      tmp;
  logic [31:0]      word;

  // Derive the next round-key word from the sliding window
  always_comb begin
    tmp = win[KeyWords-1];
    if (idx[2:0] == 3'd0) begin
      tmp = subst_bytes32({tmp[23:0], tmp[31:24]}) ^ {Rcon[3'(idx >> 3)], 24'h0};
    end else if (idx[2:0] == 3'd4) begin
      tmp = subst_bytes32(tmp);
    end
    word = (idx < IdxW'(KeyWords)) ? key[~idx[2:0]] : (win[0] ^ tmp);
  end

  // Sweep the expansion one word per cycle; restart on reset or key write
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy) begin
      idx <= idx + 1'b1;
      if (idx == LastIdx) begin
        busy <= 1'b0;
      end
    end
  end

  // Advance the window and write the memory
  always_ff @(posedge clk) begin
    if (busy && !restart) begin
      for (int k = 0; k < KeyWords - 1; k++) begin
        win[k] <= win[k+1];
      end
      win[KeyWords-1] <= word;
      rk_mem[RowW'(idx >> 2)][~idx[1:0]] <= word;
    end
  end

  // Registered read of one round key row
  always_ff @(posedge clk) begin
    rd_key <= rk_mem[rd_row];
  end

endmodule

[sv/actr_core.sv]
module actr_core #(
  parameter int ROUND_COUNT = actr_pkg::RoundCount
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [actr_pkg::BlockW-1:0]       ctr_block,
  input  logic                              out_free,
  input  logic [actr_pkg::BlockW-1:0]       rd_key,
  output logic [$clog2(ROUND_COUNT+1)-1:0]  rd_row,
  output actr_pkg::core_status_t            status,
  output logic [actr_pkg::BlockW-1:0]       keystream
);
  import actr_pkg::*;

  localparam int RowW = $clog2(ROUND_COUNT + 1);
  localparam logic [RowW-1:0] LastRow = RowW'(ROUND_COUNT);

  logic              busy;
  logic [RowW-1:0]   rnd;
  logic [BlockW-1:0] state;
  logic              at_last;

  assign at_last   = (rnd == LastRow);
  assign keystream = aes_round(state, at_last) ^ rd_key;
  assign rd_row    = start ? '0 : (at_last ? rnd : rnd + 1'b1);
  assign status.busy = busy;
  assign status.done = busy && at_last && out_free;

  // Step the round counter; hold on the last round until the output frees
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      rnd  <= '0;
    end else if (busy) begin
      if (!at_last) begin
        rnd <= rnd + 1'b1;
      end else if (out_free) begin
        busy <= 1'b0;
      end
    end
  end

  // Load the counter block, add the first key, then run the rounds
  always_ff @(posedge clk) begin
    if (start) begin
      state <= ctr_block;
    end else if (busy && !at_last) begin
      if (rnd == '0) begin
        state <= state ^ rd_key;
      end else begin
        state <= keystream;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("item started while a block is in flight");
  a_done_last: assert property (@(posedge clk) disable iff (rst) status.done |-> rnd == LastRow)
    else $error("keystream released before the last round");
  a_start_run: assert property (@(posedge clk) disable iff (rst) start |=> busy && rnd == '0)
    else $error("round sequence did not begin after start");

endmodule

[sv/aes256_ctr_block_cipher_top.sv]
// AES-256 counter-mode block cipher, one 16-byte item at a time.
// Per item: a key add, then 14 rounds in the shared round unit, one round key
// row read per cycle; the last round holds until the output register frees.
// One item in flight at a time; a new item is accepted while a result waits.
// Reset: counter, nonce and key clear; the key expansion then runs, as after
// every key word write, and no item is accepted until it completes.
module aes256_ctr_block_cipher_top #(
  parameter int ROUND_COUNT = actr_pkg::RoundCount
) (
  input  logic                          clk,
  input  logic                          rst,
  actr_in_if.sink                       in_ch,
  actr_out_if.source                    out_ch,
  input  logic                          wr_en,
  input  logic [actr_pkg::IndexW-1:0]   wr_index,
  input  logic [actr_pkg::WordW-1:0]    wr_data
);
  import actr_pkg::*;

  localparam int RowW = $clog2(ROUND_COUNT + 1);

  logic [WordW-1:0]  key_word [4];
  logic [WordW-1:0]  nonce;
  logic [WordW-1:0]  counter;
  logic [BlockW-1:0] data;
  logic [CountW-1:0] vbytes;
  logic              wrap;
  logic              key_busy;
  logic              key_write;
  logic              accept;
  logic              out_free;
  logic [RowW-1:0]   rd_row;
  logic [BlockW-1:0] rd_key;
  logic [BlockW-1:0] keystream;
  logic [BlockW-1:0] mask;
  logic [BlockW-1:0] result;
  core_status_t      cst;
  reg_index_t        widx;

  assign widx      = reg_index_t'(wr_index);
  assign key_write = wr_en && (widx == REG_KEY0 || widx == REG_KEY1 ||
                               widx == REG_KEY2 || widx == REG_KEY3);
  assign in_ch.ready = !cst.busy && !key_busy;
  assign accept    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_ch.valid || out_ch.ready;

  actr_key_store #(.ROUND_COUNT(ROUND_COUNT)) u_keys (
    .clk     (clk),
    .rst     (rst),
    .restart (key_write),
    .key     ({key_word[0], key_word[1], key_word[2], key_word[3]}),
    .rd_row  (rd_row),
    .rd_key  (rd_key),
    .busy    (key_busy)
  );

  actr_core #(.ROUND_COUNT(ROUND_COUNT)) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .ctr_block ({nonce, counter}),
    .out_free  (out_free),
    .rd_key    (rd_key),
    .rd_row    (rd_row),
    .status    (cst),
    .keystream (keystream)
  );

  // Take configuration writes and advance the counter per item; a write in the same cycle wins
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        key_word[k] <= '0;
      end
      nonce   <= '0;
      counter <= '0;
    end else if (wr_en) begin
      unique case (widx)
        REG_KEY0:  key_word[0] <= wr_data;
        REG_KEY1:  key_word[1] <= wr_data;
        REG_KEY2:  key_word[2] <= wr_data;
        REG_KEY3:  key_word[3] <= wr_data;
        REG_NONCE: nonce       <= wr_data;
        REG_START: counter     <= wr_data;
        default: ;
      endcase
    end else if (accept) begin
      counter <= counter + 1'b1;
    end
  end

  // Hold the item payload while its keystream is computed
  always_ff @(posedge clk) begin
    if (accept) begin
      data   <= {in_ch.data_high, in_ch.data_low};
      vbytes <= in_ch.valid_bytes;
      wrap   <= &counter;
    end
  end

  // Zero the bytes at or beyond the valid count
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      mask[BlockW-1-8*k -: 8] = (CountW'(k) < vbytes) ? 8'hff : 8'h00;
    end
    result = (data ^ keystream) & mask;
  end

  // Output register: load on done, drop on take
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cst.done) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cst.done) begin
      out_ch.result_high     <= result[BlockW-1:WordW];
      out_ch.result_low      <= result[WordW-1:0];
      out_ch.counter_wrapped <= wrap;
    end
  end

endmodule
